// ----- rtl/scalar_kalman_angle_filter_defines.svh -----
`ifndef SCALAR_KALMAN_ANGLE_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_ANGLE_FILTER_DEFINES_SVH

// same-cycle implication on the block clock, off during reset
`define SKAF_AST_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock, off during reset
`define SKAF_AST_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/skaf_pkg.sv -----
`timescale 1ns / 1ps
package skaf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DT_FRAC    = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int CFG_W      = 24;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;

    // digit-serial multiplier geometry
    localparam int MCAND_W    = 34;
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = 7;
    localparam int MPLR_W     = DIGIT_W * MUL_DIGITS;
    localparam int ACC_W      = MCAND_W + DIGIT_W;
    localparam int PROD_W     = ACC_W + MPLR_W;

    // bit-serial divider geometry
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int DEN_W      = 34;
    localparam int CNT_W      = 5;

    localparam int SH_DQ      = 40 - FRAC_BITS;
    localparam int SH_RR      = 32 - FRAC_BITS;
    localparam int VAR_INIT_UNITS = 4 * 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << GAIN_FRAC);
    localparam logic [DATA_W-1:0] VAR_INIT = DATA_W'(64'(VAR_INIT_UNITS) << FRAC_BITS);

    localparam logic [CFG_W-1:0] TIME_STEP_RST     = 24'd67109;
    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = 24'd262144;
    localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 24'd196608;

    localparam logic signed [PROD_W-1:0] RND_DT = PROD_W'(64'd1 << (DT_FRAC - 1));
    localparam logic signed [PROD_W-1:0] RND_DQ = PROD_W'(64'd1 << (SH_DQ - 1));
    localparam logic signed [PROD_W-1:0] RND_Q  = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] RND_RR = PROD_W'(64'd1 << (SH_RR - 1));
    localparam logic signed [PROD_W-1:0] RND_G  = PROD_W'(64'd1 << (GAIN_FRAC - 1));

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] S32_MIN = ~S32_MAX;
    localparam logic [PROD_W-1:0]        U32_MAX = PROD_W'(64'hFFFF_FFFF);

    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd2;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DQ,
        ST_QQ,
        ST_RR,
        ST_DIV,
        ST_CORR,
        ST_VAR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               command;
        logic [1:0]         axis;
        logic signed [31:0] rate;
        logic signed [31:0] measurement;
    } t_in_req;

    typedef struct packed {
        logic [1:0]         axis_out;
        logic signed [31:0] angle_estimate;
        logic [31:0]        uncertainty;
    } t_out_rsp;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = x;
        if (x > S32_MAX) begin
            y = S32_MAX;
        end else if (x < S32_MIN) begin
            y = S32_MIN;
        end
        return y[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] satu32(input logic [PROD_W-1:0] x);
        return (x > U32_MAX) ? U32_MAX[DATA_W-1:0] : x[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/scalar_kalman_angle_filter.sv -----
// filter step: states PRED, DQ, QQ, RR, DIV, CORR, VAR, DONE in order; no new request until back in IDLE
// load and out-of-range requests go from IDLE straight to DONE; DONE waits until the result register is free
// a step runs on the shared 4-bit digit multiplier (six products, 7 digits each)
// and the radix-2 gain divider (17 quotient bits)
// reset (synchronous, active low): config registers to defaults, angles to zero,
// variances to 8.0, no result pending; no clearing pass
`timescale 1ns / 1ps
`include "scalar_kalman_angle_filter_defines.svh"
module scalar_kalman_angle_filter #(
    parameter int NUM_AXES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  skaf_pkg::t_in_req                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output skaf_pkg::t_out_rsp                o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [skaf_pkg::ADDR_W-1:0]       paddr,
    input  logic [skaf_pkg::DATA_W-1:0]       pwdata,
    output logic [skaf_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    skaf_pkg::t_state r_state, n_state;
    logic [skaf_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic [skaf_pkg::CFG_W-1:0] r_time_step, n_time_step;
    logic [skaf_pkg::CFG_W-1:0] r_process_noise, n_process_noise;
    logic [skaf_pkg::CFG_W-1:0] r_measure_noise, n_measure_noise;

    logic signed [skaf_pkg::DATA_W-1:0] r_angle_store [NUM_AXES];
    logic [skaf_pkg::DATA_W-1:0]        r_variance_store [NUM_AXES];

    logic                r_out_valid, n_out_valid;
    skaf_pkg::t_out_rsp  r_out, n_out;

    logic                               r_cmd, n_cmd;
    logic [1:0]                         r_axis, n_axis;
    logic signed [skaf_pkg::DATA_W-1:0] r_rate, n_rate;
    logic signed [skaf_pkg::DATA_W-1:0] r_meas, n_meas;

    logic signed [skaf_pkg::MCAND_W-1:0] r_mcand, n_mcand;
    logic signed [skaf_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic signed [skaf_pkg::DATA_W-1:0]  r_pred, n_pred;
    logic [skaf_pkg::DATA_W-1:0]         r_p, n_p;
    logic [skaf_pkg::DEN_W-1:0]          r_den, n_den;
    logic                                r_den_zero, n_den_zero;
    logic [skaf_pkg::DEN_W-1:0]          r_rem, n_rem;
    logic [skaf_pkg::GAIN_W-1:0]         r_quo, n_quo;
    logic [skaf_pkg::GAIN_W-1:0]         r_gain, n_gain;
    logic signed [skaf_pkg::DATA_W-1:0]  r_angle_new, n_angle_new;

    logic                                w_accept;
    logic                                w_out_free;
    logic                                w_in_axis_ok;
    logic                                w_axis_ok;
    logic [AW-1:0]                       w_idx;
    logic signed [skaf_pkg::DATA_W-1:0]  w_angle_cur;
    logic [skaf_pkg::DATA_W-1:0]         w_var_cur;
    logic                                w_cfg_wr;
    logic                                w_mul_last;
    logic                                w_div_last;

    logic [skaf_pkg::DIGIT_W-1:0]        w_digit;
    logic signed [skaf_pkg::ACC_W-1:0]   w_mc_ext;
    logic signed [skaf_pkg::ACC_W-1:0]   w_dg_ext;
    logic signed [skaf_pkg::ACC_W-1:0]   w_part;
    logic signed [skaf_pkg::ACC_W-1:0]   w_acc;
    logic signed [skaf_pkg::PROD_W-1:0]  w_step;

    logic signed [skaf_pkg::PROD_W-1:0]  w_rnd_dt;
    logic signed [skaf_pkg::PROD_W-1:0]  w_rnd_dq;
    logic signed [skaf_pkg::PROD_W-1:0]  w_rnd_q;
    logic signed [skaf_pkg::PROD_W-1:0]  w_rnd_rr;
    logic signed [skaf_pkg::PROD_W-1:0]  w_rnd_g;
    logic signed [skaf_pkg::PROD_W-1:0]  w_pred_sum;
    logic [skaf_pkg::PROD_W-1:0]         w_p_sum;
    logic [skaf_pkg::PROD_W-1:0]         w_den;
    logic [skaf_pkg::PROD_W-1:0]         w_num;
    logic [skaf_pkg::DEN_W:0]            w_shift;
    logic [skaf_pkg::DEN_W:0]            w_sub;
    logic                                w_ge;
    logic [skaf_pkg::GAIN_W-1:0]         w_gain;
    logic [skaf_pkg::GAIN_W-1:0]         w_one_minus;
    logic signed [skaf_pkg::MCAND_W-1:0] w_err;
    logic signed [skaf_pkg::PROD_W-1:0]  w_ang_sum;

    logic                                w_wr_en;
    logic signed [skaf_pkg::DATA_W-1:0]  w_wr_angle;
    logic [skaf_pkg::DATA_W-1:0]         w_wr_var;

    assign o_in_stall  = (r_state != skaf_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;

    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_in_axis_ok = (int'(i_in_data.axis) < NUM_AXES);
    assign w_axis_ok    = (int'(r_axis) < NUM_AXES);
    assign w_idx        = AW'(r_axis);
    assign w_angle_cur  = r_angle_store[w_idx];
    assign w_var_cur    = r_variance_store[w_idx];
    assign w_cfg_wr     = psel && penable && pwrite && pready;
    assign w_mul_last   = (r_cnt == skaf_pkg::CNT_W'(skaf_pkg::MUL_DIGITS));
    assign w_div_last   = (r_cnt == skaf_pkg::CNT_W'(skaf_pkg::GAIN_W));

    // one 4-bit digit of the multiplier per cycle
    assign w_digit  = r_prod[skaf_pkg::DIGIT_W-1:0];
    assign w_mc_ext = skaf_pkg::ACC_W'(r_mcand);
    assign w_dg_ext = {{(skaf_pkg::ACC_W - skaf_pkg::DIGIT_W){1'b0}}, w_digit};
    assign w_part   = w_mc_ext * w_dg_ext;
    assign w_acc    = r_prod[skaf_pkg::PROD_W-1 -: skaf_pkg::ACC_W] + w_part;
    assign w_step   = {{skaf_pkg::DIGIT_W{w_acc[skaf_pkg::ACC_W-1]}}, w_acc,
                       r_prod[skaf_pkg::MPLR_W-1:skaf_pkg::DIGIT_W]};

    // rounding of finished products
    assign w_rnd_dt = (r_prod + skaf_pkg::RND_DT) >>> skaf_pkg::DT_FRAC;
    assign w_rnd_dq = (r_prod + skaf_pkg::RND_DQ) >>> skaf_pkg::SH_DQ;
    assign w_rnd_q  = (r_prod + skaf_pkg::RND_Q) >>> skaf_pkg::FRAC_BITS;
    assign w_rnd_rr = (r_prod + skaf_pkg::RND_RR) >>> skaf_pkg::SH_RR;
    assign w_rnd_g  = (r_prod + skaf_pkg::RND_G) >>> skaf_pkg::GAIN_FRAC;

    assign w_pred_sum = skaf_pkg::PROD_W'(w_angle_cur) + w_rnd_dt;
    assign w_p_sum    = skaf_pkg::PROD_W'(w_var_cur) + w_rnd_q;
    assign w_den      = skaf_pkg::PROD_W'(r_p) + w_rnd_rr;
    assign w_num      = skaf_pkg::PROD_W'({r_p, {skaf_pkg::GAIN_FRAC{1'b0}}}) + (w_den >> 1);

    // restoring divider, one quotient bit per cycle
    assign w_shift = {r_rem, r_quo[skaf_pkg::GAIN_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift - {1'b0, r_den};

    assign w_gain      = r_den_zero ? '0 :
                         ((r_quo > skaf_pkg::GAIN_ONE) ? skaf_pkg::GAIN_ONE : r_quo);
    assign w_one_minus = skaf_pkg::GAIN_ONE - r_gain;
    assign w_err       = skaf_pkg::MCAND_W'(r_meas) - skaf_pkg::MCAND_W'(r_pred);
    assign w_ang_sum   = skaf_pkg::PROD_W'(r_pred) + w_rnd_g;

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_time_step     = r_time_step;
        n_process_noise = r_process_noise;
        n_measure_noise = r_measure_noise;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out           = r_out;
        n_cmd           = r_cmd;
        n_axis          = r_axis;
        n_rate          = r_rate;
        n_meas          = r_meas;
        n_mcand         = r_mcand;
        n_prod          = r_prod;
        n_pred          = r_pred;
        n_p             = r_p;
        n_den           = r_den;
        n_den_zero      = r_den_zero;
        n_rem           = r_rem;
        n_quo           = r_quo;
        n_gain          = r_gain;
        n_angle_new     = r_angle_new;
        w_wr_en         = 1'b0;
        w_wr_angle      = r_meas;
        w_wr_var        = skaf_pkg::VAR_INIT;

        if (w_cfg_wr) begin
            unique case (paddr[skaf_pkg::ADDR_W-1:2])
                skaf_pkg::REG_TIME_STEP:     n_time_step     = pwdata[skaf_pkg::CFG_W-1:0];
                skaf_pkg::REG_PROCESS_NOISE: n_process_noise = pwdata[skaf_pkg::CFG_W-1:0];
                skaf_pkg::REG_MEASURE_NOISE: n_measure_noise = pwdata[skaf_pkg::CFG_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            skaf_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_cmd  = i_in_data.command;
                    n_axis = i_in_data.axis;
                    n_rate = i_in_data.rate;
                    n_meas = i_in_data.measurement;
                    n_cnt  = '0;
                    if ((i_in_data.command == skaf_pkg::CMD_STEP) && w_in_axis_ok) begin
                        n_state = skaf_pkg::ST_PRED;
                    end else begin
                        n_state = skaf_pkg::ST_DONE;
                    end
                end
            end
            skaf_pkg::ST_PRED, skaf_pkg::ST_DQ, skaf_pkg::ST_QQ, skaf_pkg::ST_RR,
            skaf_pkg::ST_CORR, skaf_pkg::ST_VAR: begin
                if (r_cnt == '0) begin
                    unique case (r_state)
                        skaf_pkg::ST_PRED: begin
                            n_mcand = skaf_pkg::MCAND_W'(r_rate);
                            n_prod  = skaf_pkg::PROD_W'(r_time_step);
                        end
                        skaf_pkg::ST_DQ: begin
                            n_pred  = skaf_pkg::sat32(w_pred_sum);
                            n_mcand = skaf_pkg::MCAND_W'(r_time_step);
                            n_prod  = skaf_pkg::PROD_W'(r_process_noise);
                        end
                        skaf_pkg::ST_QQ: begin
                            n_mcand = skaf_pkg::MCAND_W'(w_rnd_dq);
                            n_prod  = skaf_pkg::PROD_W'(w_rnd_dq[skaf_pkg::MPLR_W-1:0]);
                        end
                        skaf_pkg::ST_RR: begin
                            n_p     = skaf_pkg::satu32(w_p_sum);
                            n_mcand = skaf_pkg::MCAND_W'(r_measure_noise);
                            n_prod  = skaf_pkg::PROD_W'(r_measure_noise);
                        end
                        skaf_pkg::ST_CORR: begin
                            n_gain  = w_gain;
                            n_mcand = w_err;
                            n_prod  = skaf_pkg::PROD_W'(w_gain);
                        end
                        default: begin
                            n_angle_new = skaf_pkg::sat32(w_ang_sum);
                            n_mcand     = skaf_pkg::MCAND_W'(r_p);
                            n_prod      = skaf_pkg::PROD_W'(w_one_minus);
                        end
                    endcase
                end else begin
                    n_prod = w_step;
                end
                if (w_mul_last) begin
                    n_cnt = '0;
                    unique case (r_state)
                        skaf_pkg::ST_PRED: n_state = skaf_pkg::ST_DQ;
                        skaf_pkg::ST_DQ:   n_state = skaf_pkg::ST_QQ;
                        skaf_pkg::ST_QQ:   n_state = skaf_pkg::ST_RR;
                        skaf_pkg::ST_RR:   n_state = skaf_pkg::ST_DIV;
                        skaf_pkg::ST_CORR: n_state = skaf_pkg::ST_VAR;
                        default:           n_state = skaf_pkg::ST_DONE;
                    endcase
                end else begin
                    n_cnt = r_cnt + skaf_pkg::CNT_W'(1);
                end
            end
            skaf_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_den      = w_den[skaf_pkg::DEN_W-1:0];
                    n_den_zero = (w_den == '0);
                    n_rem      = w_num[skaf_pkg::GAIN_W +: skaf_pkg::DEN_W];
                    n_quo      = w_num[skaf_pkg::GAIN_W-1:0];
                end else begin
                    n_rem = w_ge ? w_sub[skaf_pkg::DEN_W-1:0] : w_shift[skaf_pkg::DEN_W-1:0];
                    n_quo = {r_quo[skaf_pkg::GAIN_W-2:0], w_ge};
                end
                if (w_div_last) begin
                    n_cnt   = '0;
                    n_state = skaf_pkg::ST_CORR;
                end else begin
                    n_cnt = r_cnt + skaf_pkg::CNT_W'(1);
                end
            end
            skaf_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.axis_out   = r_axis;
                    n_state          = skaf_pkg::ST_IDLE;
                    if (!w_axis_ok) begin
                        n_out.angle_estimate = '0;
                        n_out.uncertainty    = '0;
                    end else begin
                        w_wr_en = 1'b1;
                        if (r_cmd == skaf_pkg::CMD_LOAD) begin
                            w_wr_angle = r_meas;
                            w_wr_var   = skaf_pkg::VAR_INIT;
                        end else begin
                            w_wr_angle = r_angle_new;
                            w_wr_var   = skaf_pkg::satu32(w_rnd_g);
                        end
                        n_out.angle_estimate = w_wr_angle;
                        n_out.uncertainty    = w_wr_var;
                    end
                end
            end
            default: n_state = skaf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (paddr[skaf_pkg::ADDR_W-1:2])
            skaf_pkg::REG_TIME_STEP:     prdata = skaf_pkg::DATA_W'(r_time_step);
            skaf_pkg::REG_PROCESS_NOISE: prdata = skaf_pkg::DATA_W'(r_process_noise);
            skaf_pkg::REG_MEASURE_NOISE: prdata = skaf_pkg::DATA_W'(r_measure_noise);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= skaf_pkg::ST_IDLE;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
            r_time_step     <= skaf_pkg::TIME_STEP_RST;
            r_process_noise <= skaf_pkg::PROCESS_NOISE_RST;
            r_measure_noise <= skaf_pkg::MEASURE_NOISE_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_angle_store[i]    <= '0;
                r_variance_store[i] <= skaf_pkg::VAR_INIT;
            end
        end else begin
            r_state         <= n_state;
            r_cnt           <= n_cnt;
            r_out_valid     <= n_out_valid;
            r_time_step     <= n_time_step;
            r_process_noise <= n_process_noise;
            r_measure_noise <= n_measure_noise;
            if (w_wr_en) begin
                r_angle_store[w_idx]    <= w_wr_angle;
                r_variance_store[w_idx] <= w_wr_var;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_cmd       <= n_cmd;
        r_axis      <= n_axis;
        r_rate      <= n_rate;
        r_meas      <= n_meas;
        r_mcand     <= n_mcand;
        r_prod      <= n_prod;
        r_pred      <= n_pred;
        r_p         <= n_p;
        r_den       <= n_den;
        r_den_zero  <= n_den_zero;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_gain      <= n_gain;
        r_angle_new <= n_angle_new;
    end

    `SKAF_AST_NXT(a_step_starts_pred, w_accept && (i_in_data.command == skaf_pkg::CMD_STEP) && w_in_axis_ok, r_state == skaf_pkg::ST_PRED, "step request did not start the predict multiply")
    `SKAF_AST_IMP(a_rem_below_den, (r_state == skaf_pkg::ST_DIV) && (r_cnt != '0) && !r_den_zero, r_rem < r_den, "divider remainder not below divisor")
    `SKAF_AST_IMP(a_gain_at_most_one, r_state == skaf_pkg::ST_VAR, r_gain <= skaf_pkg::GAIN_ONE, "gain above one")
    `SKAF_AST_IMP(a_result_from_done, $rose(o_out_valid), $past(r_state) == skaf_pkg::ST_DONE, "result raised outside the done state")

endmodule

// ----- tb/tb_scalar_kalman_angle_filter.sv -----
`timescale 1ns / 1ps
module tb_scalar_kalman_angle_filter;
    import skaf_pkg::*;

    localparam int N_AXES      = 3;
    localparam int WDOG_LIMIT  = 5000;
    localparam int HOLD_LEN    = 1500;
    localparam int HOLD_AT_A   = 6000;
    localparam int HOLD_AT_B   = 70000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 250;
    localparam int TAIL_CYCLES = 80;

    localparam logic [1:0] AXIS_ROLL  = 2'd0;
    localparam logic [1:0] AXIS_PITCH = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;
    localparam logic [1:0] AXIS_BAD   = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint S_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S_MIN = -S_MAX - 1;
    localparam longint U_MAX = 64'sh0000_0000_FFFF_FFFF;
    localparam longint UNITY = 64'sd65536;
    localparam longint HALF  = 64'sd32768;

    typedef enum logic { ROW_REQ, ROW_CFG } t_row_kind;

    // config rows carry the register data in value
    typedef struct {
        t_row_kind   kind;
        logic [1:0]  regi;
        logic        command;
        logic [1:0]  axis;
        logic [31:0] rate;
        logic [31:0] value;
        bit          check;
        logic [31:0] want_angle;
        logic [31:0] want_var;
    } t_dir_row;

    localparam int DIR_N = 25;

    t_dir_row dir_tab [DIR_N] = '{
        '{ROW_REQ, REG_TIME_STEP, CMD_LOAD, AXIS_ROLL, 32'h0, 32'h7FFF_FFFF,
          1'b1, 32'h7FFF_FFFF, VAR_INIT},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_LOAD, AXIS_PITCH, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b1, 32'h8000_0000, VAR_INIT},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_PITCH, 32'h8000_0000, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h8000_0000, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_YAW, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_YAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_BAD, 32'h0000_1234, 32'h0000_5678,
          1'b1, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_LOAD, AXIS_BAD, 32'hFFFF_FFFF, 32'hDEAD_BEEF,
          1'b1, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_LOAD, AXIS_YAW, 32'h5555_5555, 32'hAAAA_AAAA,
          1'b1, 32'hAAAA_AAAA, VAR_INIT},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_YAW, 32'hAAAA_AAAA, 32'h5555_5555,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_UNUSED, CMD_STEP, AXIS_ROLL, 32'h0, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_PITCH, 32'h0001_0000, 32'h0,
          1'b0, 32'h0, 32'h0},
        // no noise at all: gain reaches one, then the denominator is zero
        '{ROW_CFG, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_PROCESS_NOISE, CMD_STEP, AXIS_ROLL, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_MEASURE_NOISE, CMD_STEP, AXIS_ROLL, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h7FFF_FFFF, 32'h0000_1000,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h0000_0001, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        // largest interval and noise: variance saturates
        '{ROW_CFG, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h0, 32'h00FF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_PROCESS_NOISE, CMD_STEP, AXIS_ROLL, 32'h0, 32'h00FF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_CFG, REG_MEASURE_NOISE, CMD_STEP, AXIS_ROLL, 32'h0, 32'h00FF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_ROLL, 32'h7FFF_FFFF, 32'h8000_0000,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_PITCH, 32'h8000_0000, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_STEP, AXIS_YAW, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ROW_REQ, REG_TIME_STEP, CMD_LOAD, AXIS_ROLL, 32'h8000_0000, 32'h0,
          1'b1, 32'h0, VAR_INIT}
    };

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_req               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_rsp              o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [ADDR_W-1:0]     paddr       = '0;
    logic [DATA_W-1:0]     pwdata      = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    logic signed [31:0]    est_angle [N_AXES];
    logic [31:0]           est_var [N_AXES];
    logic [CFG_W-1:0]      cfg_dt;
    logic [CFG_W-1:0]      cfg_q;
    logic [CFG_W-1:0]      cfg_r;
    t_out_rsp              pending_est [$];
    int                    fail_cnt    = 0;
    int                    quiet_cycles = 0;
    bit                    offering    = 1'b0;
    int unsigned           burst_left  = 0;

    scalar_kalman_angle_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint clamp_s32(input longint x);
        if (x > S_MAX) begin
            return S_MAX;
        end
        if (x < S_MIN) begin
            return S_MIN;
        end
        return x;
    endfunction

    // one filter update on the predictor state, returns the estimate it reports
    function automatic t_out_rsp kalman_step(input t_in_req req);
        t_out_rsp res;
        longint   dt, pred, dq, qq, p, rr, den, gain, err, angle;
        res = '0;
        res.axis_out = req.axis;
        if (req.axis >= N_AXES) begin
            return res;
        end
        if (req.command == CMD_LOAD) begin
            est_angle[req.axis] = req.measurement;
            est_var[req.axis]   = VAR_INIT;
        end else begin
            dt   = longint'(cfg_dt);
            pred = (longint'($signed(req.rate)) * dt + (64'sd1 <<< 23)) >>> 24;
            pred = clamp_s32(longint'(est_angle[req.axis]) + pred);
            dq   = (dt * longint'(cfg_q) + (64'sd1 <<< 23)) >>> 24;
            qq   = (dq * dq + HALF) >>> 16;
            p    = longint'(est_var[req.axis]) + qq;
            if (p > U_MAX) begin
                p = U_MAX;
            end
            rr   = (longint'(cfg_r) * longint'(cfg_r) + HALF) >>> 16;
            den  = p + rr;
            gain = (den == 0) ? 64'sd0 : ((p <<< 16) + (den >>> 1)) / den;
            if (gain > UNITY) begin
                gain = UNITY;
            end
            err   = longint'($signed(req.measurement)) - pred;
            angle = clamp_s32(pred + ((gain * err + HALF) >>> 16));
            p     = ((UNITY - gain) * p + HALF) >>> 16;
            if (p > U_MAX) begin
                p = U_MAX;
            end
            est_angle[req.axis] = angle[31:0];
            est_var[req.axis]   = p[31:0];
        end
        res.angle_estimate = est_angle[req.axis];
        res.uncertainty    = est_var[req.axis];
        return res;
    endfunction

    task automatic send_req(input t_in_req req, input bit use_want, input t_out_rsp want);
        t_out_rsp    est;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        offering = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        est = kalman_step(req);
        pending_est.push_back(use_want ? want : est);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            gap = ($urandom_range(6) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 10);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 5);
        end
    endtask

    task automatic wait_drained();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_est.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [1:0] idx, input logic [31:0] wdat,
                             output logic [31:0] rdat);
        psel   <= 1'b1;
        pwrite <= wr;
        paddr  <= {idx, 2'b00};
        pwdata <= wdat;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdat = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [31:0] wdat);
        logic [31:0] rd;
        wait_drained();
        apb_cycle(1'b1, idx, wdat, rd);
        case (idx)
            REG_TIME_STEP: begin
                cfg_dt = wdat[CFG_W-1:0];
            end
            REG_PROCESS_NOISE: begin
                cfg_q = wdat[CFG_W-1:0];
            end
            REG_MEASURE_NOISE: begin
                cfg_r = wdat[CFG_W-1:0];
            end
            default: begin
            end
        endcase
        if (idx != REG_UNUSED) begin
            apb_cycle(1'b0, idx, '0, rd);
            if (rd !== 32'(wdat[CFG_W-1:0])) begin
                $display("%0t: register %0d readback: expected %h, got %h",
                         $time, idx, 32'(wdat[CFG_W-1:0]), rd);
                fail_cnt++;
            end
        end
    endtask

    initial begin : stimulus
        t_in_req          req;
        t_out_rsp         want;
        logic [CFG_W-1:0] dt, q, r;
        int               ph, n, sel;
        for (int a = 0; a < N_AXES; a++) begin
            est_angle[a] = '0;
            est_var[a]   = VAR_INIT;
        end
        cfg_dt = TIME_STEP_RST;
        cfg_q  = PROCESS_NOISE_RST;
        cfg_r  = MEASURE_NOISE_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                set_reg(dir_tab[i].regi, dir_tab[i].value);
            end else begin
                req  = {dir_tab[i].command, dir_tab[i].axis, dir_tab[i].rate,
                        dir_tab[i].value};
                want = {dir_tab[i].axis, dir_tab[i].want_angle, dir_tab[i].want_var};
                send_req(req, dir_tab[i].check, want);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    dt = TIME_STEP_RST;
                    q  = PROCESS_NOISE_RST;
                    r  = MEASURE_NOISE_RST;
                end
                2: begin
                    dt = '1;
                    q  = '1;
                    r  = '1;
                end
                3: begin
                    dt = '0;
                    q  = '0;
                    r  = '0;
                end
                4: begin
                    // tiny noise so variance collapses and the divide sees zero
                    dt = CFG_W'($urandom_range(32'h0002_0000));
                    q  = CFG_W'($urandom_range(255));
                    r  = CFG_W'($urandom_range(181));
                end
                6: begin
                    dt = CFG_W'($urandom);
                    q  = CFG_W'($urandom);
                    r  = '1;
                end
                default: begin
                    dt = CFG_W'($urandom);
                    q  = CFG_W'($urandom);
                    r  = CFG_W'($urandom);
                end
            endcase
            set_reg(REG_TIME_STEP, {8'($urandom), dt});
            set_reg(REG_PROCESS_NOISE, {8'($urandom), q});
            set_reg(REG_MEASURE_NOISE, {8'($urandom), r});

            for (n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(99);
                req.axis    = (sel < 5) ? AXIS_BAD : 2'($urandom_range(N_AXES - 1));
                req.command = (sel < 2 || (sel >= 5 && sel < 15)) ? CMD_LOAD : CMD_STEP;
                case ($urandom_range(9))
                    0: req.rate = $urandom;
                    1: req.rate = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: req.rate = int'($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
                endcase
                case ($urandom_range(9))
                    0: req.measurement = $urandom;
                    1: req.measurement = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF
                                                                  : 32'h8000_0000;
                    default: begin
                        if (req.axis < N_AXES) begin
                            req.measurement = est_angle[req.axis]
                                + (int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
                        end else begin
                            req.measurement = $urandom;
                        end
                    end
                endcase
                send_req(req, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_est.size() == 0) begin
            $display("scalar_kalman_angle_filter regression: pass");
        end else begin
            $display("scalar_kalman_angle_filter regression: fail");
        end
        $finish;
    end

    // result stall pattern with two long hold-offs that back the block up
    initial begin : result_stall
        int unsigned cyc, len, mode, hold_left;
        cyc       = 0;
        hold_left = 0;
        forever begin
            mode = $urandom_range(3);
            len  = $urandom_range(5, 200);
            repeat (len) begin
                @(posedge i_clk);
                cyc++;
                if (cyc == HOLD_AT_A || cyc == HOLD_AT_B) begin
                    hold_left = HOLD_LEN;
                end
                if (hold_left != 0) begin
                    hold_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    case (mode)
                        0: i_out_stall <= 1'b0;
                        1: i_out_stall <= 1'($urandom_range(1));
                        2: i_out_stall <= ($urandom_range(3) == 0);
                        default: i_out_stall <= ((cyc % 7) < 3);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_est.size() == 0) begin
                $display("%0t: unexpected result: axis %0d angle %h variance %h", $time,
                         o_out_data.axis_out, o_out_data.angle_estimate,
                         o_out_data.uncertainty);
                fail_cnt++;
            end else begin
                want = pending_est.pop_front();
                if (o_out_data.axis_out !== want.axis_out) begin
                    $display("%0t: axis_out: expected %0d, got %0d", $time,
                             want.axis_out, o_out_data.axis_out);
                    fail_cnt++;
                end
                if (o_out_data.angle_estimate !== want.angle_estimate) begin
                    $display("%0t: angle_estimate: expected %h, got %h", $time,
                             want.angle_estimate, o_out_data.angle_estimate);
                    fail_cnt++;
                end
                if (o_out_data.uncertainty !== want.uncertainty) begin
                    $display("%0t: uncertainty: expected %h, got %h", $time,
                             want.uncertainty, o_out_data.uncertainty);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t: no request or result moved for %0d cycles, %0d results owed",
                         $time, quiet_cycles, pending_est.size());
                $display("scalar_kalman_angle_filter regression: fail");
                $finish;
            end
        end
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/skaf_pkg.sv
rtl/scalar_kalman_angle_filter.sv
tb/tb_scalar_kalman_angle_filter.sv
